### hw/rtl/mtg_pkg.sv
// mtg_pkg: shared constants, types and functions for the MT19937 generator.
// Used by the front end, the engine, the output queue and the top level.
// No dependencies.
package mtg_pkg;

  localparam int STATE_WORDS  = 624;
  localparam int SHIFT_OFFSET = 397;
  localparam int TWIST_WRAP   = STATE_WORDS - SHIFT_OFFSET;
  localparam int WARMUP_STEPS = 51;
  localparam int MAX_RUN      = 64;
  localparam int ADDR_W       = 10;
  localparam int WORD_W       = 32;
  localparam int COUNT_W      = 7;
  localparam int OUTQ_DEPTH   = 4;
  localparam int OUTQ_PTR_W   = 2;
  localparam int OUTQ_CNT_W   = 3;

  localparam logic [WORD_W-1:0] LCG_MULT     = 32'd69069;
  localparam logic [WORD_W-1:0] RESET_SEED   = 32'd1958;
  localparam logic [WORD_W-1:0] TWIST_MATRIX = 32'h9908_B0DF;
  localparam logic [WORD_W-1:0] TEMPER_B     = 32'h9D2C_5680;
  localparam logic [WORD_W-1:0] TEMPER_C     = 32'hEFC6_0000;

  localparam logic OP_GENERATE = 1'b0;
  localparam logic OP_RESEED   = 1'b1;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COUNT_W-1:0] count_t;

  typedef struct packed {
    logic   reseed;
    count_t count;
  } cmd_t;

  typedef struct packed {
    logic  valid;
    logic  last;
    word_t number;
  } res_t;

  function automatic word_t temper(input word_t y_in);
    word_t y;
    y = y_in;
    y = y ^ (y >> 11);
    y = y ^ ((y << 7) & TEMPER_B);
    y = y ^ ((y << 15) & TEMPER_C);
    y = y ^ (y >> 18);
    return y;
  endfunction

  function automatic word_t twist_word(input word_t cur, input word_t nxt, input word_t far);
    word_t y;
    word_t ya;
    y  = {cur[WORD_W-1], nxt[WORD_W-2:0]};
    ya = y >> 1;
    if (y[0]) begin
      ya = ya ^ TWIST_MATRIX;
    end
    return far ^ ya;
  endfunction

endpackage

### hw/rtl/mtg_ram.sv
// mtg_ram: generic RAM, one write port and two read ports, registered reads.
// No dependencies.
module mtg_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 624
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] ra_addr,
  output logic [WIDTH-1:0]         ra_data,
  input  logic [$clog2(DEPTH)-1:0] rb_addr,
  output logic [WIDTH-1:0]         rb_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    ra_data <= mem[ra_addr];
    rb_data <= mem[rb_addr];
  end

endmodule

### hw/rtl/mtg_front.sv
// mtg_front: accepts requests, drops empty runs, clamps counts, queues commands.
// Depends on mtg_pkg.
module mtg_front import mtg_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  logic   in_opcode,
  input  count_t in_count,
  output cmd_t   cmd,
  output logic   cmd_valid,
  input  logic   cmd_pop
);

  cmd_t       q [2];
  logic       rd_ptr;
  logic       wr_ptr;
  logic [1:0] fill;
  logic       keep;
  cmd_t       entry;

  assign in_ready  = !rst && (fill != 2'd2);
  assign keep      = in_valid && in_ready && ((in_opcode == OP_RESEED) || (in_count != '0));
  assign cmd       = q[rd_ptr];
  assign cmd_valid = (fill != 2'd0);

  always_comb begin
    entry.reseed = (in_opcode == OP_RESEED);
    entry.count  = (in_count > count_t'(MAX_RUN)) ? count_t'(MAX_RUN) : in_count;
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q[wr_ptr] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= 1'b0;
      wr_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (keep) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({keep, cmd_pop})
        2'b10:   fill <= fill + 2'd1;
        2'b01:   fill <= fill - 2'd1;
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/mtg_engine.sv
// mtg_engine: seeding, in-place twist and word reads over the state table.
// Depends on mtg_pkg and mtg_ram.
module mtg_engine import mtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  word_t                 cfg_wdata,
  input  cmd_t                  cmd,
  input  logic                  cmd_valid,
  output logic                  cmd_pop,
  input  logic [OUTQ_CNT_W-1:0] outq_fill,
  output res_t                  res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WARM   = 3'd1;
  localparam logic [2:0] S_FILL   = 3'd2;
  localparam logic [2:0] S_GEN    = 3'd3;
  localparam logic [2:0] S_TW_PRE = 3'd4;
  localparam logic [2:0] S_TW_LD  = 3'd5;
  localparam logic [2:0] S_TW_RD  = 3'd6;
  localparam logic [2:0] S_TW_WR  = 3'd7;

  logic [2:0] state;
  word_t      seed;
  word_t      x;
  word_t      lcg_next;
  addr_t      cnt;
  addr_t      pos;
  count_t     run_left;
  logic       rd_pending;
  logic       rd_last;
  word_t      cur;

  logic       we;
  addr_t      waddr;
  word_t      wdata;
  addr_t      ra_addr;
  addr_t      rb_addr;
  word_t      ra_data;
  word_t      rb_data;
  addr_t      nxt_i;
  addr_t      far_i;
  logic       issue;
  logic [OUTQ_CNT_W:0] credit_sum;

  mtg_ram #(
    .WIDTH (WORD_W),
    .DEPTH (STATE_WORDS)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .ra_addr (ra_addr),
    .ra_data (ra_data),
    .rb_addr (rb_addr),
    .rb_data (rb_data)
  );

  assign lcg_next   = x * LCG_MULT + 32'd1;
  assign nxt_i      = (cnt == addr_t'(STATE_WORDS - 1)) ? '0 : cnt + addr_t'(1);
  assign far_i      = (cnt < addr_t'(TWIST_WRAP)) ? cnt + addr_t'(SHIFT_OFFSET)
                                                  : cnt - addr_t'(TWIST_WRAP);
  assign credit_sum = (OUTQ_CNT_W+1)'(outq_fill) + (OUTQ_CNT_W+1)'(rd_pending);
  assign issue      = (state == S_GEN) && (run_left != '0) &&
                      (pos != addr_t'(STATE_WORDS)) &&
                      (credit_sum < (OUTQ_CNT_W+1)'(OUTQ_DEPTH));
  assign cmd_pop    = (state == S_IDLE) && cmd_valid;

  assign res.valid  = rd_pending;
  assign res.last   = rd_last;
  assign res.number = temper(ra_data);

  always_comb begin
    we      = 1'b0;
    waddr   = cnt;
    wdata   = lcg_next;
    ra_addr = pos;
    rb_addr = far_i;
    unique case (state)
      S_FILL: begin
        we = 1'b1;
      end
      S_TW_PRE: begin
        ra_addr = '0;
      end
      S_TW_RD: begin
        ra_addr = nxt_i;
      end
      S_TW_WR: begin
        we    = 1'b1;
        wdata = twist_word(cur, ra_data, rb_data);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_last <= (run_left == count_t'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_WARM;
      seed       <= RESET_SEED;
      x          <= RESET_SEED;
      cnt        <= '0;
      pos        <= addr_t'(STATE_WORDS);
      run_left   <= '0;
      rd_pending <= 1'b0;
    end else begin
      if (cfg_we) begin
        seed <= cfg_wdata;
      end
      rd_pending <= issue;
      if (issue) begin
        pos      <= pos + addr_t'(1);
        run_left <= run_left - count_t'(1);
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            if (cmd.reseed) begin
              x     <= seed;
              cnt   <= '0;
              state <= S_WARM;
            end else begin
              run_left <= cmd.count;
              state    <= S_GEN;
            end
          end
        end
        S_WARM: begin
          x <= lcg_next;
          if (cnt == addr_t'(WARMUP_STEPS - 1)) begin
            cnt   <= '0;
            state <= S_FILL;
          end else begin
            cnt <= cnt + addr_t'(1);
          end
        end
        S_FILL: begin
          x <= lcg_next;
          if (cnt == addr_t'(STATE_WORDS - 1)) begin
            pos   <= addr_t'(STATE_WORDS);
            state <= S_IDLE;
          end else begin
            cnt <= cnt + addr_t'(1);
          end
        end
        S_GEN: begin
          if (run_left == '0) begin
            state <= S_IDLE;
          end else if (pos == addr_t'(STATE_WORDS)) begin
            cnt   <= '0;
            state <= S_TW_PRE;
          end
        end
        S_TW_PRE: begin
          state <= S_TW_LD;
        end
        S_TW_LD: begin
          cur   <= ra_data;
          state <= S_TW_RD;
        end
        S_TW_RD: begin
          state <= S_TW_WR;
        end
        S_TW_WR: begin
          cur <= ra_data;
          if (cnt == addr_t'(STATE_WORDS - 1)) begin
            pos   <= '0;
            state <= S_GEN;
          end else begin
            cnt   <= nxt_i;
            state <= S_TW_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### hw/rtl/mtg_outq.sv
// mtg_outq: four-entry result queue between the engine and the output stream.
// Depends on mtg_pkg.
module mtg_outq import mtg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  res_t                  res,
  output logic [OUTQ_CNT_W-1:0] fill,
  output logic                  out_valid,
  input  logic                  out_ready,
  output word_t                 out_number,
  output logic                  out_last
);

  word_t           num_q  [OUTQ_DEPTH];
  logic            last_q [OUTQ_DEPTH];
  logic [OUTQ_PTR_W-1:0] rd_ptr;
  logic [OUTQ_PTR_W-1:0] wr_ptr;
  logic            pop;

  assign out_valid  = !rst && (fill != '0);
  assign out_number = num_q[rd_ptr];
  assign out_last   = last_q[rd_ptr];
  assign pop        = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (res.valid) begin
      num_q[wr_ptr]  <= res.number;
      last_q[wr_ptr] <= res.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ptr <= '0;
      wr_ptr <= '0;
      fill   <= '0;
    end else begin
      if (res.valid) begin
        wr_ptr <= wr_ptr + OUTQ_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + OUTQ_PTR_W'(1);
      end
      case ({res.valid, pop})
        2'b10:   fill <= fill + OUTQ_CNT_W'(1);
        2'b01:   fill <= fill - OUTQ_CNT_W'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

### hw/rtl/mersenne_twister_generator_top.sv
// mersenne_twister_generator_top: MT19937 generator with a 624-word state table.
// Depends on mtg_pkg, mtg_front, mtg_engine (with mtg_ram) and mtg_outq.
//
// Usage:
//   s_axis carries requests: opcode 0 asks for count numbers (clamped to 64,
//   count 0 does nothing), opcode 1 reseeds the table from the seed register.
//   m_axis returns one tempered word per transfer, tlast on the last of a run.
//   cfg_we/cfg_wdata write the seed; it only takes effect at the next reseed.
// Flow and throughput:
//   With the engine idle and no twist due, the first word of a run is valid
//   after the request passes the command queue, the engine state, the
//   registered table read and the result queue; words then follow one per
//   cycle while m_axis_tready is high and no twist is due.
//   Whenever the read position runs off the table end, the in-place twist
//   runs first: S_TW_PRE, S_TW_LD, then an S_TW_RD/S_TW_WR read/write loop
//   per table word on the table memory. A reseed is one decode in S_IDLE,
//   51 warm-up LCG steps and 624 table writes.
// Reset:
//   Reset reseeds from seed 1958 (no words out meanwhile);
//   requests are still queued, two deep.
// Stalls:
//   A four-entry result queue absorbs a stalled receiver; reads stop when full.
module mersenne_twister_generator_top import mtg_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  cfg_we,
  input  word_t cfg_wdata,
  input  logic  s_axis_tvalid,
  output logic  s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] opcode, [7:1] count
  output logic  m_axis_tvalid,
  input  logic  m_axis_tready,
  output word_t m_axis_tdata,        // [31:0] number
  output logic  m_axis_tlast
);

  cmd_t                  cmd;
  logic                  cmd_valid;
  logic                  cmd_pop;
  res_t                  res;
  logic [OUTQ_CNT_W-1:0] outq_fill;

  mtg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_opcode (s_axis_tdata[0]),
    .in_count  (s_axis_tdata[7:1]),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop)
  );

  mtg_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .cmd_valid (cmd_valid),
    .cmd_pop   (cmd_pop),
    .outq_fill (outq_fill),
    .res       (res)
  );

  mtg_outq u_outq (
    .clk        (clk),
    .rst        (rst),
    .res        (res),
    .fill       (outq_fill),
    .out_valid  (m_axis_tvalid),
    .out_ready  (m_axis_tready),
    .out_number (m_axis_tdata),
    .out_last   (m_axis_tlast)
  );

endmodule

### hw/rtl/mtg_checker.sv
// mtg_checker: port-level assertions for the generator, bound to the top level.
// Depends on mersenne_twister_generator_top port names.
module mtg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic        m_axis_tlast
);

  a_rst_no_out: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

  a_rst_ready: assert property (@(posedge clk) $fell(rst) |-> s_axis_tready)
    else $error("request queue not empty after reset");

  a_seed_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !m_axis_tvalid ##1 !m_axis_tvalid)
    else $error("output during reset seeding");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("stalled output transfer changed");

endmodule

bind mersenne_twister_generator_top mtg_checker u_mtg_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
